/* sv/spd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the sorted point store.
// No dependencies; used by every module of the block.
package spd_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int COORD_BITS_DEF = 24;
  localparam int IN_COORD_BITS  = 24;
  localparam int RADIUS_BITS    = 23;
  localparam int SQ_BITS        = 2 * RADIUS_BITS;
  localparam int INDEX_BITS     = 8;
  localparam int COUNT_BITS     = 9;
  localparam int IN_TDATA_BITS  = 80;
  localparam int OUT_TDATA_BITS = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic rotate;
    logic insert;
  } cell_ctrl_t;

endpackage

/* sv/spd_cell.sv */
`timescale 1ns / 1ps
// One storage cell of the point chain: holds one point; rotates, or on insert shifts or takes the new point.
// Depends on spd_pkg.
module spd_cell #(
  parameter int K          = 0,
  parameter int CB         = spd_pkg::COORD_BITS_DEF,
  parameter int FW         = 9
) (
  input  logic                    clk,
  input  spd_pkg::cell_ctrl_t     ctrl,
  input  logic [FW-1:0]           fill,
  input  logic [3*CB-1:0]         new_pt,
  input  logic [3*CB-1:0]         right_pt,
  input  logic [3*CB-1:0]         left_pt,
  input  logic                    lt_prev,
  output logic [3*CB-1:0]         pt,
  output logic                    lt
);
  import spd_pkg::*;

  localparam logic [FW-1:0] IDX = FW'(K);

  assign lt = (IDX < fill) && ($signed(pt[CB-1:0]) < $signed(new_pt[CB-1:0]));

  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      pt <= right_pt;
    end else if (ctrl.insert && !lt) begin
      pt <= lt_prev ? new_pt : left_pt;
    end
  end

endmodule

/* sv/spd_dist.sv */
`timescale 1ns / 1ps
// Three-stage squared distance test of a streamed point against the target.
// Depends on spd_pkg.
module spd_dist #(
  parameter int CB = spd_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [3*CB-1:0]                 a,
  input  logic [3*CB-1:0]                 b,
  input  logic [spd_pkg::RADIUS_BITS-1:0] radius,
  input  logic [spd_pkg::SQ_BITS-1:0]     r_sq,
  output logic                            hit
);
  import spd_pkg::*;

  localparam int DW = (CB + 1 > RADIUS_BITS) ? CB + 1 : RADIUS_BITS;

  logic [DW-1:0]          d_next [3];
  logic [DW-1:0]          d      [3];
  logic                   far_next;
  logic                   v1, far1, v2, far2;
  logic [SQ_BITS-1:0]     sq [3];
  logic [SQ_BITS+1:0]     sum;

  always_comb begin
    logic signed [CB:0] diff;
    far_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      diff = (CB+1)'($signed(a[i*CB +: CB])) - (CB+1)'($signed(b[i*CB +: CB]));
      d_next[i] = diff[CB] ? DW'(-diff) : DW'(diff);
      far_next = far_next | (d_next[i] > DW'(radius));
    end
  end

  assign sum = (SQ_BITS+2)'(sq[0]) + (SQ_BITS+2)'(sq[1]) + (SQ_BITS+2)'(sq[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      hit <= 1'b0;
    end else begin
      v1  <= in_valid;
      v2  <= v1;
      hit <= v2 && !far2 && (sum <= (SQ_BITS+2)'(r_sq));
    end
    far1 <= far_next;
    far2 <= far1;
    for (int i = 0; i < 3; i++) begin
      d[i]  <= d_next[i];
      sq[i] <= d[i][RADIUS_BITS-1:0] * d[i][RADIUS_BITS-1:0];
    end
  end

endmodule

/* sv/sorted_point_store_density.sv */
`timescale 1ns / 1ps
// Sorted point store with fixed-radius neighbour count. Points sit in a ring of
// CAPACITY cells ordered by x. An insert makes one full rotation of the ring to
// count the stored points with smaller x, then shifts the cells. A query makes
// one rotation to pick out the named entry, then a second that streams every
// stored point past the three-stage distance unit. A refused insert or an
// out-of-range query goes straight to the result. Depends on spd_pkg, spd_cell
// and spd_dist.
module sorted_point_store_density #(
  parameter int CAPACITY   = spd_pkg::CAPACITY_DEF,
  parameter int COORD_BITS = spd_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [spd_pkg::IN_TDATA_BITS-1:0]   s_tdata,  // x_coord, y_coord, z_coord, entry_index
  input  logic                                s_tuser,  // command
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [spd_pkg::OUT_TDATA_BITS-1:0]  m_tdata,  // position, density, stored_count, pad
  output logic [1:0]                          m_tuser,  // status
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spd_pkg::RADIUS_BITS-1:0]     cfg_data
);
  import spd_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int CW = $clog2(CAPACITY + 3);
  localparam logic [FW-1:0] FULL     = FW'(CAPACITY);
  localparam logic [CW-1:0] LAST_ROT = CW'(CAPACITY - 1);
  localparam logic [CW-1:0] LAST_MEA = CW'(CAPACITY + 2);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_INSERT  = 5'b00100,
    S_MEASURE = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t                 state;
  logic [FW-1:0]          fill;
  logic [CW-1:0]          cnt;
  logic [FW-1:0]          pos;
  logic [FW-1:0]          dens;
  logic                   cmd;
  logic [INDEX_BITS-1:0]  entry;
  logic [3*CB-1:0]        new_pt;
  logic [3*CB-1:0]        target;
  logic [RADIUS_BITS-1:0] radius;
  logic [SQ_BITS-1:0]     r_sq;
  logic [1:0]             res_status;
  logic [FW-1:0]          res_pos;
  logic [FW-1:0]          res_dens;
  logic [FW-1:0]          res_count;
  logic                   hit;
  logic                   meas_valid;
  cell_ctrl_t             ctrl;
  logic [3*CB-1:0]        in_pt;
  logic [3*CB-1:0]        pt [CAPACITY];
  logic                   lt [CAPACITY];
  logic                   load_out;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign load_out  = (state == S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_pt[i*CB +: CB] = CB'($signed(s_tdata[i*IN_COORD_BITS +: IN_COORD_BITS]));
    end
  end

  always_comb begin
    ctrl.rotate = (state == S_SCAN) || ((state == S_MEASURE) && (cnt < CW'(CAPACITY)));
    ctrl.insert = (state == S_INSERT);
  end

  assign meas_valid = (state == S_MEASURE) && (cnt < CW'(fill));

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    localparam int RK = (k + 1) % CAPACITY;
    logic [3*CB-1:0] left_pt;
    logic            lt_prev;
    if (k == 0) begin : g_head
      assign left_pt = '0;
      assign lt_prev = 1'b1;
    end else begin : g_body
      assign left_pt = pt[k-1];
      assign lt_prev = lt[k-1];
    end
    spd_cell #(.K(k), .CB(CB), .FW(FW)) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .fill     (fill),
      .new_pt   (new_pt),
      .right_pt (pt[RK]),
      .left_pt  (left_pt),
      .lt_prev  (lt_prev),
      .pt       (pt[k]),
      .lt       (lt[k])
    );
  end

  spd_dist #(.CB(CB)) u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (meas_valid),
    .a        (target),
    .b        (pt[0]),
    .radius   (radius),
    .r_sq     (r_sq),
    .hit      (hit)
  );

  always_ff @(posedge clk) begin
    r_sq <= radius * radius;
    if (rst) begin
      radius <= '0;
    end else if (cfg_valid && cfg_ready) begin
      radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cnt  <= '0;
            pos  <= '0;
            dens <= '0;
            if (s_tuser == CMD_INSERT) begin
              if (fill == FULL) begin
                res_status <= ST_FULL;
                res_pos    <= '0;
                res_dens   <= '0;
                res_count  <= fill;
                state      <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              if (32'(s_tdata[3*IN_COORD_BITS +: INDEX_BITS]) >= 32'(fill)) begin
                res_status <= ST_RANGE;
                res_pos    <= '0;
                res_dens   <= '0;
                res_count  <= fill;
                state      <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (cmd == CMD_INSERT) begin
            if ((cnt < CW'(fill)) &&
                ($signed(pt[0][CB-1:0]) < $signed(new_pt[CB-1:0]))) begin
              pos <= pos + 1'b1;
            end
          end else if (32'(cnt) == 32'(entry)) begin
            target <= pt[0];
          end
          if (cnt == LAST_ROT) begin
            cnt   <= '0;
            state <= (cmd == CMD_INSERT) ? S_INSERT : S_MEASURE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_INSERT: begin
          fill       <= fill + 1'b1;
          res_status <= ST_OK;
          res_pos    <= pos;
          res_dens   <= '0;
          res_count  <= fill + 1'b1;
          state      <= S_DONE;
        end
        S_MEASURE: begin
          if (cnt == LAST_MEA) begin
            res_status <= ST_OK;
            res_pos    <= '0;
            res_dens   <= dens + FW'(hit);
            res_count  <= fill;
            state      <= S_DONE;
          end else begin
            dens <= dens + FW'(hit);
            cnt  <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd    <= s_tuser;
      entry  <= s_tdata[3*IN_COORD_BITS +: INDEX_BITS];
      new_pt <= in_pt;
    end
    if (load_out) begin
      m_tuser <= res_status;
      m_tdata <= {(OUT_TDATA_BITS - INDEX_BITS - 2*COUNT_BITS)'(0),
                  COUNT_BITS'(res_count), COUNT_BITS'(res_dens), INDEX_BITS'(res_pos)};
    end
  end

endmodule
